[src/pss_pkg.sv]
// Shared types, codes and constants of the power supervisor and sequencer.
`default_nettype none

package pss_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int RESULT_W   = 19;

    localparam logic [CFG_ADDR_W-1:0] REG_BATT_WARN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BATT_CUTOFF  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BUS_TOL      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RUN_CURRENT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_READ_IVL     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RESET_WAIT   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_COPROC_EN    = 3'd6;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_PWR_DOWN   = 2'd1;
    localparam logic [1:0] OP_CHIP_RESET = 2'd2;

    localparam logic [2:0] MAIN_CODE_INIT      = 3'd0;
    localparam logic [2:0] MAIN_CODE_SAMPLE    = 3'd1;
    localparam logic [2:0] MAIN_CODE_WAIT      = 3'd2;
    localparam logic [2:0] MAIN_CODE_PD_SAMPLE = 3'd3;
    localparam logic [2:0] MAIN_CODE_PD_WAIT   = 3'd4;
    localparam logic [2:0] MAIN_CODE_PD_DONE   = 3'd5;

    localparam logic [9:0] BEEP_NONE_MS     = 10'd0;
    localparam logic [9:0] BEEP_LOW_BATT_MS = 10'd50;
    localparam logic [9:0] BEEP_RESET_MS    = 10'd200;
    localparam logic [9:0] BEEP_START_MS    = 10'd800;

    localparam logic [15:0] VBUS_NOMINAL_MV = 16'd5000;
    localparam logic [14:0] VBAT_BEEP_MIN_MV = 15'd6000;

    typedef enum logic [5:0] {
        MS_INIT      = 6'b000001,
        MS_SAMPLE    = 6'b000010,
        MS_WAIT      = 6'b000100,
        MS_PD_SAMPLE = 6'b001000,
        MS_PD_WAIT   = 6'b010000,
        MS_PD_DONE   = 6'b100000
    } main_state_t;

    typedef enum logic [2:0] {
        RS_IDLE  = 3'b001,
        RS_START = 3'b010,
        RS_WAIT  = 3'b100
    } reset_state_t;

    typedef struct packed {
        logic [14:0] battery_warn_mv;
        logic [14:0] battery_cutoff_mv;
        logic [12:0] bus_tolerance_mv;
        logic [14:0] running_current_ma;
        logic [15:0] read_interval_ticks;
        logic [15:0] reset_wait_ticks;
        logic        coproc_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        battery_warn_mv:     15'd7000,
        battery_cutoff_mv:   15'd6600,
        bus_tolerance_mv:    13'd250,
        running_current_ma:  15'd100,
        read_interval_ticks: 16'd10,
        reset_wait_ticks:    16'd10,
        coproc_enable:       1'b1
    };

    typedef struct packed {
        logic [9:0] beep_ms;
        logic       coproc_running;
        logic       power_good;
        logic       chip_ready;
        logic       chip_power;
        logic       coproc_power;
        logic       switch_open;
        logic [2:0] main_state;
    } result_t;

    function automatic logic [2:0] main_code(main_state_t st);
        logic [2:0] code;
        unique case (st)
            MS_INIT:      code = MAIN_CODE_INIT;
            MS_SAMPLE:    code = MAIN_CODE_SAMPLE;
            MS_WAIT:      code = MAIN_CODE_WAIT;
            MS_PD_SAMPLE: code = MAIN_CODE_PD_SAMPLE;
            MS_PD_WAIT:   code = MAIN_CODE_PD_WAIT;
            MS_PD_DONE:   code = MAIN_CODE_PD_DONE;
            default:      code = MAIN_CODE_INIT;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[src/power_supervisor_sequencer_top.sv]
// Top level of the power supervisor and sequencer: ports, registers and item pipeline.
//
//  Channel  Direction  Payload
//  cfg_*    in         register index, write data; written at once, no read-back
//  s_*      in         tuser: op; tdata: vbat_mv, vbus_mv, coproc_ma
//  m_*      out        tdata: main_state .. beep_ms, one item per input item
//
// One item is accepted per cycle while the output is not stalled; an accepted item sits in the input
// register, and its result is loaded into the output register when that register is free or being read.
// All state is updated by a single pass of compare and count logic, at the edge that loads that result.
// Reset is synchronous and active low; it restores the register defaults and the state.
// A stalled output holds its item, and a new item is still taken while the input register is free.
`default_nettype none

module power_supervisor_sequencer_top #(
    parameter int COUNT_BITS = pss_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [pss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [pss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // From bit 0: vbat_mv[14:0], vbus_mv[29:15], coproc_ma[45:30], zero fill.
    input  wire logic [pss_pkg::S_TDATA_W-1:0]   s_tdata,
    // From bit 0: op[1:0].
    input  wire logic [pss_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // From bit 0: main_state[2:0], switch_open, coproc_power, chip_power, chip_ready,
    // power_good, coproc_running, beep_ms[18:9], zero fill.
    output logic [pss_pkg::M_TDATA_W-1:0]        m_tdata
);
    import pss_pkg::*;

    cfg_t                   cfg_reg;
    logic                   in_valid_reg;
    logic [S_TUSER_W-1:0]   in_op_reg;
    logic [S_TDATA_W-1:0]   in_data_reg;
    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg;
    logic                   advance, fire;
    result_t                res;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_BATT_WARN:   cfg_reg.battery_warn_mv     <= cfg_wdata[14:0];
                REG_BATT_CUTOFF: cfg_reg.battery_cutoff_mv   <= cfg_wdata[14:0];
                REG_BUS_TOL:     cfg_reg.bus_tolerance_mv    <= cfg_wdata[12:0];
                REG_RUN_CURRENT: cfg_reg.running_current_ma  <= cfg_wdata[14:0];
                REG_READ_IVL:    cfg_reg.read_interval_ticks <= cfg_wdata;
                REG_RESET_WAIT:  cfg_reg.reset_wait_ticks    <= cfg_wdata;
                REG_COPROC_EN:   cfg_reg.coproc_enable       <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    pss_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .cfg       (cfg_reg),
        .op        (in_op_reg),
        .vbat_mv   (in_data_reg[14:0]),
        .vbus_mv   (in_data_reg[29:15]),
        .coproc_ma (in_data_reg[45:30]),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {(M_TDATA_W - RESULT_W)'(0), res};
        end
    end

endmodule

`default_nettype wire

[src/pss_core.sv]
// Supervisor state machines, tick counters and power flags, updated once per item.
`default_nettype none

module pss_core #(
    parameter int COUNT_BITS = pss_pkg::COUNT_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire pss_pkg::cfg_t     cfg,
    input  wire logic [1:0]        op,
    input  wire logic [14:0]       vbat_mv,
    input  wire logic [14:0]       vbus_mv,
    input  wire logic [15:0]       coproc_ma,
    output pss_pkg::result_t       res
);
    import pss_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    main_state_t            main_reg, main_next;
    reset_state_t           rst_reg, rst_next;
    logic [COUNT_BITS-1:0]  icnt_reg, icnt_next, icnt_inc;
    logic [COUNT_BITS-1:0]  rcnt_reg, rcnt_next, rcnt_inc;
    logic                   good_reg, good_next;
    logic                   cur_reg, cur_next;
    logic                   coproc_reg, coproc_next;
    logic                   switch_reg, switch_next;
    logic                   chip_reg, chip_next;
    logic [9:0]             beep;
    logic                   good_s, cur_s, low_batt;
    logic                   icnt_done, rcnt_done;
    logic [15:0]            vbus_ext, tol_ext;

    assign vbus_ext = {1'b0, vbus_mv};
    assign tol_ext  = {3'b000, cfg.bus_tolerance_mv};

    // Lower bus bound is written as vbus + tol > 5000 so a tolerance above 5000 needs no sign.
    assign good_s = (vbus_ext < (VBUS_NOMINAL_MV + tol_ext)) &&
                    ((vbus_ext + tol_ext) > VBUS_NOMINAL_MV) &&
                    (vbat_mv > cfg.battery_cutoff_mv);
    assign cur_s    = $signed(coproc_ma) > $signed({1'b0, cfg.running_current_ma});
    assign low_batt = (vbat_mv < cfg.battery_warn_mv) && (vbat_mv > VBAT_BEEP_MIN_MV);

    assign icnt_inc  = (&icnt_reg) ? icnt_reg : icnt_reg + 1'b1;
    assign rcnt_inc  = (&rcnt_reg) ? rcnt_reg : rcnt_reg + 1'b1;
    assign icnt_done = CMP_W'(icnt_inc) > CMP_W'(cfg.read_interval_ticks);
    assign rcnt_done = CMP_W'(rcnt_inc) > CMP_W'(cfg.reset_wait_ticks);

    always_comb begin
        main_next   = main_reg;
        rst_next    = rst_reg;
        icnt_next   = icnt_reg;
        rcnt_next   = rcnt_reg;
        good_next   = good_reg;
        cur_next    = cur_reg;
        coproc_next = coproc_reg;
        switch_next = switch_reg;
        chip_next   = chip_reg;
        beep        = BEEP_NONE_MS;
        if (fire) begin
            unique case (op)
                OP_PWR_DOWN: begin
                    main_next = MS_PD_SAMPLE;
                end
                OP_CHIP_RESET: begin
                    rst_next = RS_START;
                end
                OP_TICK: begin
                    unique case (main_reg)
                        MS_INIT: begin
                            beep      = BEEP_START_MS;
                            good_next = good_s;
                            cur_next  = cur_s;
                            main_next = MS_SAMPLE;
                        end
                        MS_SAMPLE: begin
                            good_next = good_s;
                            cur_next  = cur_s;
                            if (!good_s) begin
                                switch_next = 1'b1;
                            end
                            if (low_batt) begin
                                beep = BEEP_LOW_BATT_MS;
                            end
                            if (good_s && cfg.coproc_enable) begin
                                coproc_next = 1'b1;
                            end
                            icnt_next = '0;
                            main_next = MS_WAIT;
                        end
                        MS_WAIT: begin
                            icnt_next = icnt_inc;
                            if (icnt_done) begin
                                main_next = MS_SAMPLE;
                            end
                        end
                        MS_PD_WAIT: begin
                            icnt_next = icnt_inc;
                            if (icnt_done) begin
                                main_next = MS_PD_SAMPLE;
                            end
                        end
                        MS_PD_SAMPLE: begin
                            good_next = good_s;
                            cur_next  = cur_s;
                            if (!good_s) begin
                                switch_next = 1'b1;
                            end
                            if (!cur_s) begin
                                main_next = MS_PD_DONE;
                            end else begin
                                icnt_next = '0;
                                main_next = MS_PD_WAIT;
                            end
                        end
                        MS_PD_DONE: begin
                            switch_next = 1'b1;
                        end
                        default: begin
                            main_next = MS_INIT;
                        end
                    endcase

                    unique case (rst_reg)
                        RS_IDLE: begin
                        end
                        RS_START: begin
                            if (main_next != MS_INIT) begin
                                chip_next = 1'b0;
                                rcnt_next = '0;
                                rst_next  = RS_WAIT;
                                beep      = BEEP_RESET_MS;
                            end
                        end
                        RS_WAIT: begin
                            rcnt_next = rcnt_inc;
                            if (rcnt_done) begin
                                chip_next = 1'b1;
                                rst_next  = RS_IDLE;
                            end
                        end
                        default: begin
                            chip_next = 1'b1;
                            rst_next  = RS_IDLE;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_reg   <= MS_INIT;
            rst_reg    <= RS_IDLE;
            icnt_reg   <= '0;
            rcnt_reg   <= '0;
            good_reg   <= 1'b0;
            cur_reg    <= 1'b0;
            coproc_reg <= 1'b0;
            switch_reg <= 1'b0;
            chip_reg   <= 1'b1;
        end else begin
            main_reg   <= main_next;
            rst_reg    <= rst_next;
            icnt_reg   <= icnt_next;
            rcnt_reg   <= rcnt_next;
            good_reg   <= good_next;
            cur_reg    <= cur_next;
            coproc_reg <= coproc_next;
            switch_reg <= switch_next;
            chip_reg   <= chip_next;
        end
    end

    always_comb begin
        res.main_state     = main_code(main_next);
        res.switch_open    = switch_next;
        res.coproc_power   = coproc_next;
        res.chip_power     = chip_next;
        res.chip_ready     = (rst_next == RS_IDLE);
        res.power_good     = good_next;
        res.coproc_running = cur_next && coproc_next;
        res.beep_ms        = beep;
    end

endmodule

`default_nettype wire

[src/pss_checker.sv]
// Port-level checks on the supervisor result stream, bound to the top level.
`default_nettype none

module pss_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [pss_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pss_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result item changed or was dropped.");

    a_ready_powered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> m_tdata[5])
        else $error("Chip reset machine idle while chip power is off.");

    a_running_powered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[4])
        else $error("Coprocessor reported running without coprocessor power.");

    a_beep_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:9] == BEEP_NONE_MS || m_tdata[18:9] == BEEP_LOW_BATT_MS ||
                      m_tdata[18:9] == BEEP_RESET_MS || m_tdata[18:9] == BEEP_START_MS))
        else $error("Beep length is not one of the defined lengths.");

    a_main_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= MAIN_CODE_PD_DONE)
        else $error("Main state code out of range.");

endmodule

bind power_supervisor_sequencer_top pss_checker u_pss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
